// File: rtl/sact_pkg.sv
`timescale 1ns / 1ps
package sact_pkg;

    localparam int MAX_SETS   = 1024;
    localparam int MAX_WAYS   = 8;
    localparam int SET_W      = 10;
    localparam int WAY_W      = 3;
    localparam int TAG_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int RANK_W     = 3;
    localparam int CNT_W      = 32;
    localparam int EMPTY_W    = 14;
    localparam int IB_W       = 4;
    localparam int OFF_W      = 5;
    localparam int WAYS_W     = 4;
    localparam int POL_W      = 2;
    localparam int SEED_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 208;

    localparam logic [IB_W-1:0] MAX_IB = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED        = 3'd4;

    localparam logic [POL_W-1:0] POL_FIFO   = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU    = 2'd1;
    localparam logic [POL_W-1:0] POL_RANDOM = 2'd2;

    localparam logic [1:0] KIND_HIT        = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CONFLICT   = 2'd2;
    localparam logic [1:0] KIND_CAPACITY   = 2'd3;

    localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
        logic [WAY_W-1:0]                fifo;
    } set_row_t;

    typedef struct packed {
        logic             wr_en;
        logic [SET_W-1:0] wr_addr;
        logic             rd_en;
        logic [SET_W-1:0] rd_addr;
    } mem_ctl_t;

endpackage

// File: rtl/sact_store.sv
`timescale 1ns / 1ps
module sact_store (
    input  logic               aclk,
    input  sact_pkg::mem_ctl_t ctl,
    input  sact_pkg::set_row_t wr_row,
    output sact_pkg::set_row_t rd_row
);
    import sact_pkg::*;

    set_row_t mem [MAX_SETS];
    set_row_t rd_row_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= wr_row;
        end
        if (ctl.rd_en) begin
            rd_row_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

// File: rtl/set_assoc_cache_tag_lookup.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: address
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: lookup result and totals
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Each address passes through these states in order: idle, set read,
// a scan of the set one way per cycle through one tag comparator, write-back and result
// load; a hit ends the scan at its way. A random victim adds a bit-serial modulo step.
// After reset, and after a write of index_bits or ways_in_use, a clearing pass sweeps
// all 1024 set rows, one per cycle; no address is taken meanwhile.
// The result register frees the scanner: a new address is taken while a result waits.
module set_assoc_cache_tag_lookup (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sact_pkg::ADDR_W-1:0]         s_axis_tdata,  // [31:0] address
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] hit, [2:1] miss_kind, [5:3] way, [15:6] set_index, [47:16] tag,
    // [79:48] access_count, [111:80] hit_count, [143:112] compulsory_count,
    // [175:144] conflict_count, [207:176] capacity_count
    output logic [sact_pkg::OUT_W-1:0]          m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sact_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SCAN, S_MOD, S_WRITE, S_DONE
    } state_t;

    function automatic logic [IB_W-1:0] eff_ib_f(input logic [IB_W-1:0] ib);
        eff_ib_f = (ib > MAX_IB) ? MAX_IB : ib;
    endfunction

    function automatic logic [WAYS_W-1:0] eff_ways_f(input logic [WAYS_W-1:0] w);
        logic [WAYS_W-1:0] r;
        r = w;
        if (w == '0) r = WAYS_W'(1);
        if (w > WAYS_W'(MAX_WAYS)) r = WAYS_W'(MAX_WAYS);
        eff_ways_f = r;
    endfunction

    function automatic logic [EMPTY_W-1:0] lines_f(input logic [IB_W-1:0] ib,
                                                   input logic [WAYS_W-1:0] w);
        lines_f = EMPTY_W'(eff_ways_f(w)) << eff_ib_f(ib);
    endfunction

    state_t              state_reg;
    logic [SET_W-1:0]    clear_cnt_reg;
    logic [IB_W-1:0]     index_bits_reg;
    logic [OFF_W-1:0]    offset_bits_reg;
    logic [WAYS_W-1:0]   ways_reg;
    logic [POL_W-1:0]    policy_reg;
    logic [SEED_W-1:0]   lfsr_reg;
    logic [EMPTY_W-1:0]  empty_reg;
    logic [CNT_W-1:0]    access_reg, hits_reg, comp_reg, conf_reg, cap_reg;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    set_row_t            row_reg;
    logic [WAY_W-1:0]    way_cnt_reg;
    logic                free_found_reg;
    logic [WAY_W-1:0]    free_way_reg;
    logic [RANK_W-1:0]   best_rank_reg;
    logic [WAY_W-1:0]    best_way_reg;
    logic                hit_reg;
    logic [1:0]          kind_reg;
    logic [WAY_W-1:0]    way_reg;
    logic                fifo_upd_reg;
    logic [WAY_W-1:0]    fifo_next_reg;
    logic [WAYS_W-1:0]   rem_reg;
    logic [SEED_W-1:0]   div_reg;
    logic [3:0]          div_cnt_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;

    logic [IB_W-1:0]     eff_ib;
    logic [WAYS_W-1:0]   eff_ways;
    logic                s_fire, cfg_fire;
    logic [SET_W-1:0]    set_in, set_mask;
    logic [5:0]          shamt;
    logic [TAG_W-1:0]    tag_in;
    logic                cur_valid, cur_hit, free_now_found, best_take, last_way;
    logic [RANK_W-1:0]   cur_rank;
    logic [WAY_W-1:0]    free_now_way;
    logic [SEED_W-1:0]   lfsr_step;
    logic [WAYS_W:0]     rem_shift;
    logic [WAYS_W-1:0]   rem_next;
    logic [WAY_W-1:0]    fifo_p, fifo_n;
    logic [RANK_W-1:0]   old_rank;
    set_row_t            new_row, wr_row, rd_row;
    mem_ctl_t            mem_ctl;

    sact_store u_store (
        .aclk   (aclk),
        .ctl    (mem_ctl),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    assign eff_ib   = eff_ib_f(index_bits_reg);
    assign eff_ways = eff_ways_f(ways_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // split the address
    assign set_mask = SET_W'((11'd1 << eff_ib) - 11'd1);
    assign set_in   = SET_W'(s_axis_tdata >> offset_bits_reg) & set_mask;
    assign shamt    = 6'(offset_bits_reg) + 6'(eff_ib);
    assign tag_in   = (shamt >= 6'd32) ? '0 : (s_axis_tdata >> shamt);

    // one way per cycle through the shared comparator
    assign cur_valid      = row_reg.valid[way_cnt_reg];
    assign cur_rank       = row_reg.rank[way_cnt_reg];
    assign cur_hit        = cur_valid && (row_reg.tag[way_cnt_reg] == tag_reg);
    assign free_now_found = free_found_reg || !cur_valid;
    assign free_now_way   = free_found_reg ? free_way_reg : way_cnt_reg;
    assign best_take      = (way_cnt_reg == '0) || (cur_rank > best_rank_reg);
    assign last_way       = ({1'b0, way_cnt_reg} == (eff_ways - WAYS_W'(1)));

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);

    // restoring modulo, one dividend bit per cycle
    assign rem_shift = {rem_reg, div_reg[SEED_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, eff_ways}) ?
                       WAYS_W'(rem_shift - {1'b0, eff_ways}) : WAYS_W'(rem_shift);

    assign fifo_p = ({1'b0, row_reg.fifo} >= eff_ways) ? '0 : row_reg.fifo;
    assign fifo_n = ({1'b0, fifo_p} + WAYS_W'(1) == eff_ways) ? '0 : fifo_p + WAY_W'(1);

    assign old_rank = row_reg.rank[way_reg];

    always_comb begin
        new_row = row_reg;
        if (!hit_reg) begin
            new_row.valid[way_reg] = 1'b1;
            new_row.tag[way_reg]   = tag_reg;
        end
        if (policy_reg == POL_LRU) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (WAYS_W'(i) < eff_ways) begin
                    if (WAY_W'(i) == way_reg) begin
                        new_row.rank[i] = '0;
                    end else if (row_reg.rank[i] <= old_rank && row_reg.rank[i] != '1) begin
                        new_row.rank[i] = row_reg.rank[i] + RANK_W'(1);
                    end
                end
            end
        end
        if (fifo_upd_reg) begin
            new_row.fifo = fifo_next_reg;
        end
    end

    always_comb begin
        mem_ctl.rd_en   = s_fire;
        mem_ctl.rd_addr = set_in;
        mem_ctl.wr_en   = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        mem_ctl.wr_addr = (state_reg == S_CLEAR) ? clear_cnt_reg : set_reg;
        wr_row          = (state_reg == S_CLEAR) ? '0 : new_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clear_cnt_reg   <= '0;
            index_bits_reg  <= '0;
            offset_bits_reg <= OFF_W'(2);
            ways_reg        <= WAYS_W'(1);
            policy_reg      <= POL_FIFO;
            lfsr_reg        <= SEED_W'(1);
            empty_reg       <= EMPTY_W'(1);
            access_reg      <= '0;
            hits_reg        <= '0;
            comp_reg        <= '0;
            conf_reg        <= '0;
            cap_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clear_cnt_reg <= clear_cnt_reg + SET_W'(1);
                    if (clear_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        set_reg   <= set_in;
                        tag_reg   <= tag_in;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    row_reg        <= rd_row;
                    way_cnt_reg    <= '0;
                    free_found_reg <= 1'b0;
                    state_reg      <= S_SCAN;
                end
                S_SCAN: begin
                    fifo_upd_reg <= 1'b0;
                    if (cur_hit) begin
                        hit_reg   <= 1'b1;
                        kind_reg  <= KIND_HIT;
                        way_reg   <= way_cnt_reg;
                        state_reg <= S_WRITE;
                    end else begin
                        free_found_reg <= free_now_found;
                        free_way_reg   <= free_now_way;
                        if (best_take) begin
                            best_rank_reg <= cur_rank;
                            best_way_reg  <= way_cnt_reg;
                        end
                        way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                        if (last_way) begin
                            hit_reg   <= 1'b0;
                            state_reg <= S_WRITE;
                            if (free_now_found) begin
                                kind_reg <= KIND_COMPULSORY;
                                way_reg  <= free_now_way;
                            end else begin
                                kind_reg <= (empty_reg != '0) ? KIND_CONFLICT : KIND_CAPACITY;
                                if (eff_ways == WAYS_W'(1)) begin
                                    way_reg <= '0;
                                end else if (policy_reg == POL_LRU) begin
                                    way_reg <= best_take ? way_cnt_reg : best_way_reg;
                                end else if (policy_reg == POL_RANDOM) begin
                                    lfsr_reg    <= lfsr_step;
                                    div_reg     <= lfsr_step;
                                    rem_reg     <= '0;
                                    div_cnt_reg <= '0;
                                    state_reg   <= S_MOD;
                                end else begin
                                    way_reg       <= fifo_p;
                                    fifo_next_reg <= fifo_n;
                                    fifo_upd_reg  <= 1'b1;
                                end
                            end
                        end
                    end
                end
                S_MOD: begin
                    rem_reg     <= rem_next;
                    div_reg     <= div_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15) begin
                        way_reg   <= WAY_W'(rem_next);
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    access_reg <= access_reg + CNT_W'(1);
                    case (kind_reg)
                        KIND_HIT:        hits_reg <= hits_reg + CNT_W'(1);
                        KIND_COMPULSORY: begin
                            comp_reg <= comp_reg + CNT_W'(1);
                            if (empty_reg != '0) empty_reg <= empty_reg - EMPTY_W'(1);
                        end
                        KIND_CONFLICT:   conf_reg <= conf_reg + CNT_W'(1);
                        default:         cap_reg  <= cap_reg + CNT_W'(1);
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= {cap_reg, conf_reg, comp_reg, hits_reg, access_reg,
                                        tag_reg, set_reg, way_reg, kind_reg, hit_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg_fire) begin
                case (cfg_index)
                    REG_INDEX_BITS: begin
                        index_bits_reg <= cfg_data[IB_W-1:0];
                        empty_reg      <= lines_f(cfg_data[IB_W-1:0], ways_reg);
                        clear_cnt_reg  <= '0;
                        state_reg      <= S_CLEAR;
                    end
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFF_W-1:0];
                    REG_WAYS: begin
                        ways_reg      <= cfg_data[WAYS_W-1:0];
                        empty_reg     <= lines_f(index_bits_reg, cfg_data[WAYS_W-1:0]);
                        clear_cnt_reg <= '0;
                        state_reg     <= S_CLEAR;
                    end
                    REG_POLICY: policy_reg <= cfg_data[POL_W-1:0];
                    REG_SEED: lfsr_reg <= (cfg_data == '0) ? SEED_W'(1) : cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("address taken during clearing pass");

    a_access_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |=> (access_reg == $past(access_reg) + CNT_W'(1)))
        else $error("access total did not advance by one");

    a_empty_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && kind_reg == KIND_COMPULSORY && empty_reg != '0 && !cfg_fire)
        |=> (empty_reg == $past(empty_reg) - EMPTY_W'(1)))
        else $error("empty line count not dropped on compulsory miss");

    a_hit_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[0] == (m_data_reg[2:1] == KIND_HIT)))
        else $error("hit flag disagrees with miss kind");
`endif

endmodule
